FILE: rtl/spre_pkg.sv
// Shared types, constants and the sequencer microprogram of the relaxation engine.
`timescale 1ns / 1ps
`default_nettype none

package spre_pkg;

    // Default sizes, handed to the top level parameters
    localparam int MAX_VERTICES_DEF = 64;
    localparam int MAX_EDGES_DEF    = 256;
    localparam int WEIGHT_BITS_DEF  = 16;

    // Fixed port field widths
    localparam int VERTEX_W   = 6;
    localparam int WEIGHT_W   = 16;
    localparam int DIST_OUT_W = 32;
    localparam int VCOUNT_W   = 7;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_VERTEX = 2'd1;
    localparam logic [VCOUNT_W-1:0]  VERTEX_COUNT_RST = 7'd64;
    localparam logic [VERTEX_W-1:0]  START_VERTEX_RST = 6'd0;

    // Input beat: one directed edge
    typedef struct packed {
        logic [VERTEX_W-1:0]        edge_from;
        logic [VERTEX_W-1:0]        edge_to;
        logic signed [WEIGHT_W-1:0] edge_weight;
        logic                       final_edge;
    } t_in_beat;

    // Output beat: one vertex result or the negative-cycle flag
    typedef struct packed {
        logic [VERTEX_W-1:0]          vertex_index;
        logic signed [DIST_OUT_W-1:0] path_distance;
        logic                         reachable;
        logic                         negative_cycle;
        logic                         last_result;
    } t_out_beat;

    // Microprogram step addresses
    localparam int UPC_W = 4;
    localparam logic [UPC_W-1:0] S_IDLE     = 4'd0;
    localparam logic [UPC_W-1:0] S_INIT     = 4'd1;
    localparam logic [UPC_W-1:0] S_EDGE_RD  = 4'd2;
    localparam logic [UPC_W-1:0] S_DIST_RD  = 4'd3;
    localparam logic [UPC_W-1:0] S_RELAX    = 4'd4;
    localparam logic [UPC_W-1:0] S_PASS_END = 4'd5;
    localparam logic [UPC_W-1:0] S_OUT_RD   = 4'd6;
    localparam logic [UPC_W-1:0] S_OUT_WR   = 4'd7;
    localparam logic [UPC_W-1:0] S_OUT_NEXT = 4'd8;
    localparam logic [UPC_W-1:0] S_NEG      = 4'd9;
    localparam logic [UPC_W-1:0] S_LAST     = S_NEG;

    // Datapath strobes carried in each control word
    typedef struct packed {
        logic in_open;       // input channel open, edges stored
        logic init;          // set up distances for a run
        logic edge_rd;       // fetch edge at the edge pointer
        logic dist_rd_edge;  // fetch distances of the fetched edge ends
        logic relax;         // test relaxation of the fetched edge, apply it outside the check pass
        logic pass_end;      // rewind edge pointer, count the pass
        logic dist_rd_vtx;   // fetch distance of the result vertex
        logic out_dist;      // load a distance result beat
        logic out_neg;       // load the negative-cycle beat
        logic clr_edges;     // empty the edge store
    } t_ctl;

    // Jump condition select
    typedef enum logic [2:0] {
        C_NEVER      = 3'd0,
        C_NO_START   = 3'd1,
        C_EDGES_DONE = 3'd2,
        C_CYCLE_HIT  = 3'd3,
        C_CHECKING   = 3'd4,
        C_OUT_BUSY   = 3'd5,
        C_VTX_DONE   = 3'd6
    } t_cond_sel;

    // Status from the datapath that the jumps test
    typedef struct packed {
        logic start;
        logic edges_done;
        logic cycle_hit;
        logic checking;
        logic out_busy;
        logic vtx_done;
    } t_flags;

    // One control word: strobes, condition, target if taken, target if not
    typedef struct packed {
        t_ctl             ctl;
        t_cond_sel        cond;
        logic [UPC_W-1:0] jt;
        logic [UPC_W-1:0] jf;
    } t_uword;

    // Microprogram ROM
    function automatic t_uword ucode(input logic [UPC_W-1:0] addr);
        t_uword w;
        w = '0;
        w.cond = C_NEVER;
        case (addr)
            S_IDLE: begin
                w.ctl.in_open = 1'b1;
                w.cond = C_NO_START;
                w.jt = S_IDLE;
                w.jf = S_INIT;
            end
            S_INIT: begin
                w.ctl.init = 1'b1;
                w.jf = S_EDGE_RD;
            end
            S_EDGE_RD: begin
                w.ctl.edge_rd = 1'b1;
                w.cond = C_EDGES_DONE;
                w.jt = S_PASS_END;
                w.jf = S_DIST_RD;
            end
            S_DIST_RD: begin
                w.ctl.dist_rd_edge = 1'b1;
                w.jf = S_RELAX;
            end
            S_RELAX: begin
                w.ctl.relax = 1'b1;
                w.cond = C_CYCLE_HIT;
                w.jt = S_NEG;
                w.jf = S_EDGE_RD;
            end
            S_PASS_END: begin
                w.ctl.pass_end = 1'b1;
                w.cond = C_CHECKING;
                w.jt = S_OUT_RD;
                w.jf = S_EDGE_RD;
            end
            S_OUT_RD: begin
                w.ctl.dist_rd_vtx = 1'b1;
                w.ctl.clr_edges = 1'b1;
                w.jf = S_OUT_WR;
            end
            S_OUT_WR: begin
                w.ctl.out_dist = 1'b1;
                w.cond = C_OUT_BUSY;
                w.jt = S_OUT_WR;
                w.jf = S_OUT_NEXT;
            end
            S_OUT_NEXT: begin
                w.cond = C_VTX_DONE;
                w.jt = S_IDLE;
                w.jf = S_OUT_RD;
            end
            S_NEG: begin
                w.ctl.out_neg = 1'b1;
                w.ctl.clr_edges = 1'b1;
                w.cond = C_OUT_BUSY;
                w.jt = S_NEG;
                w.jf = S_IDLE;
            end
            default: begin
                w.jf = S_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/spre_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module spre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                        i_wdata,
    input  wire logic                                    i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, holds between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/spre_seq.sv
// Microprogram sequencer: step counter, control ROM and conditional jumps.
`timescale 1ns / 1ps
`default_nettype none

module spre_seq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire spre_pkg::t_flags i_flags,
    output spre_pkg::t_ctl       o_ctl
);

    logic [spre_pkg::UPC_W-1:0] r_upc;
    logic [spre_pkg::UPC_W-1:0] n_upc;
    spre_pkg::t_uword           word;
    logic                       taken;

    assign word = spre_pkg::ucode(r_upc);

    // Condition select
    always_comb begin
        case (word.cond)
            spre_pkg::C_NEVER:      taken = 1'b0;
            spre_pkg::C_NO_START:   taken = !i_flags.start;
            spre_pkg::C_EDGES_DONE: taken = i_flags.edges_done;
            spre_pkg::C_CYCLE_HIT:  taken = i_flags.cycle_hit;
            spre_pkg::C_CHECKING:   taken = i_flags.checking;
            spre_pkg::C_OUT_BUSY:   taken = i_flags.out_busy;
            spre_pkg::C_VTX_DONE:   taken = i_flags.vtx_done;
            default:                taken = 1'b0;
        endcase
        n_upc = taken ? word.jt : word.jf;
    end

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= spre_pkg::S_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign o_ctl = word.ctl;

endmodule

`default_nettype wire

FILE: rtl/spre_dpath.sv
// Datapath: edge store, distance tables, known flags, counters and result register.
`timescale 1ns / 1ps
`default_nettype none

module spre_dpath #(
    parameter int MAX_VERTICES = spre_pkg::MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = spre_pkg::MAX_EDGES_DEF,
    parameter int WEIGHT_BITS  = spre_pkg::WEIGHT_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire spre_pkg::t_ctl                      i_ctl,
    output spre_pkg::t_flags                         o_flags,
    input  wire logic [spre_pkg::VCOUNT_W-1:0]       i_vertex_count,
    input  wire logic [spre_pkg::VERTEX_W-1:0]       i_start_vertex,
    input  wire logic                                i_in_accept,
    input  wire spre_pkg::t_in_beat                  i_in_data,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output spre_pkg::t_out_beat                      o_out_data
);

    localparam int VW     = $clog2(MAX_VERTICES);
    localparam int NW     = $clog2(MAX_VERTICES + 1);
    localparam int CW     = spre_pkg::VCOUNT_W;
    localparam int EAW    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW    = $clog2(MAX_EDGES + 1);
    localparam int EW     = 2 * spre_pkg::VERTEX_W + WEIGHT_BITS;
    localparam int DW_RAW = WEIGHT_BITS + $clog2(MAX_VERTICES) + $clog2(MAX_EDGES) + 2;
    localparam int DW     = (DW_RAW > spre_pkg::DIST_OUT_W) ? DW_RAW : spre_pkg::DIST_OUT_W;

    // Control registers
    logic [ECW-1:0]          r_edges_loaded, n_edges_loaded;
    logic [ECW-1:0]          r_eidx, n_eidx;
    logic [NW-1:0]           r_nv, n_nv;
    logic [VW-1:0]           r_passes_left, n_passes_left;
    logic                    r_check, n_check;
    logic [NW-1:0]           r_vtx, n_vtx;
    logic [MAX_VERTICES-1:0] r_known, n_known;
    logic                    r_out_valid, n_out_valid;
    spre_pkg::t_out_beat     r_out;

    // Edge store
    logic                    edge_we;
    logic [EW-1:0]           edge_wdata;
    logic [EW-1:0]           edge_rdata;
    logic [spre_pkg::VERTEX_W-1:0] e_src, e_dst;
    logic signed [WEIGHT_BITS-1:0] e_wt;

    // Distance tables (two copies give two read ports)
    logic                    dist_we;
    logic [VW-1:0]           dist_waddr;
    logic [DW-1:0]           dist_wdata;
    logic                    dist_re_a;
    logic [VW-1:0]           dist_raddr_a;
    logic [DW-1:0]           dist_rdata_a, dist_rdata_b;
    logic signed [DW-1:0]    d_src, d_dst, cand;

    logic [CW-1:0]           nv_c;
    logic                    start_ok;
    logic                    in_range, known_src, known_dst, hit;
    logic                    out_free, ld_dist, ld_neg, known_v;
    logic [NW-1:0]           vtx_next;

    // Edge packing: source, destination, low weight bits
    assign edge_we    = i_in_accept && (r_edges_loaded != ECW'(MAX_EDGES));
    assign edge_wdata = {i_in_data.edge_from, i_in_data.edge_to,
                         WEIGHT_BITS'($unsigned(i_in_data.edge_weight))};
    assign e_src = edge_rdata[EW-1 -: spre_pkg::VERTEX_W];
    assign e_dst = edge_rdata[EW-1-spre_pkg::VERTEX_W -: spre_pkg::VERTEX_W];
    assign e_wt  = edge_rdata[WEIGHT_BITS-1:0];

    spre_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (edge_we),
        .i_waddr (r_edges_loaded[EAW-1:0]),
        .i_wdata (edge_wdata),
        .i_re    (i_ctl.edge_rd),
        .i_raddr (r_eidx[EAW-1:0]),
        .o_rdata (edge_rdata)
    );

    // Clamp vertex count into 1..MAX_VERTICES
    always_comb begin
        if (i_vertex_count == '0) begin
            nv_c = CW'(1);
        end else if (i_vertex_count > CW'(MAX_VERTICES)) begin
            nv_c = CW'(MAX_VERTICES);
        end else begin
            nv_c = i_vertex_count;
        end
    end
    assign start_ok = CW'(i_start_vertex) < nv_c;

    // Relaxation test of the fetched edge
    assign d_src     = dist_rdata_a;
    assign d_dst     = dist_rdata_b;
    assign cand      = d_src + DW'(e_wt);
    assign in_range  = (CW'(e_src) < CW'(r_nv)) && (CW'(e_dst) < CW'(r_nv));
    assign known_src = r_known[e_src[VW-1:0]];
    assign known_dst = r_known[e_dst[VW-1:0]];
    assign hit       = in_range && known_src && (!known_dst || (cand < d_dst));

    // Distance write: start vertex at set-up, destination on relaxation
    assign dist_we    = (i_ctl.init && start_ok) || (i_ctl.relax && hit && !r_check);
    assign dist_waddr = i_ctl.init ? i_start_vertex[VW-1:0] : e_dst[VW-1:0];
    assign dist_wdata = i_ctl.init ? '0 : cand;
    assign dist_re_a    = i_ctl.dist_rd_edge || i_ctl.dist_rd_vtx;
    assign dist_raddr_a = i_ctl.dist_rd_vtx ? r_vtx[VW-1:0] : e_src[VW-1:0];

    spre_ram #(.WIDTH(DW), .DEPTH(MAX_VERTICES)) u_dist_ram_a (
        .i_clk   (i_clk),
        .i_we    (dist_we),
        .i_waddr (dist_waddr),
        .i_wdata (dist_wdata),
        .i_re    (dist_re_a),
        .i_raddr (dist_raddr_a),
        .o_rdata (dist_rdata_a)
    );

    spre_ram #(.WIDTH(DW), .DEPTH(MAX_VERTICES)) u_dist_ram_b (
        .i_clk   (i_clk),
        .i_we    (dist_we),
        .i_waddr (dist_waddr),
        .i_wdata (dist_wdata),
        .i_re    (i_ctl.dist_rd_edge),
        .i_raddr (e_dst[VW-1:0]),
        .o_rdata (dist_rdata_b)
    );

    // Result register handshake
    assign out_free = !r_out_valid || !i_out_stall;
    assign ld_dist  = i_ctl.out_dist && out_free;
    assign ld_neg   = i_ctl.out_neg && out_free;
    assign known_v  = r_known[r_vtx[VW-1:0]];
    assign vtx_next = r_vtx + NW'(1);

    // Next-state of the control registers
    always_comb begin
        n_edges_loaded = r_edges_loaded;
        n_eidx         = r_eidx;
        n_nv           = r_nv;
        n_passes_left  = r_passes_left;
        n_check        = r_check;
        n_vtx          = r_vtx;
        n_known        = r_known;
        n_out_valid    = r_out_valid;

        if (edge_we) begin
            n_edges_loaded = r_edges_loaded + ECW'(1);
        end
        if (i_ctl.init) begin
            n_nv          = NW'(nv_c);
            n_passes_left = VW'(nv_c - CW'(1));
            n_check       = (nv_c == CW'(1));
            n_eidx        = '0;
            n_vtx         = '0;
            n_known       = '0;
            if (start_ok) begin
                n_known[i_start_vertex[VW-1:0]] = 1'b1;
            end
        end
        if (i_ctl.relax) begin
            n_eidx = r_eidx + ECW'(1);
            if (hit && !r_check) begin
                n_known[e_dst[VW-1:0]] = 1'b1;
            end
        end
        // Pass end: the last relaxing pass hands over to the check pass
        if (i_ctl.pass_end) begin
            n_eidx = '0;
            if (!r_check) begin
                n_passes_left = r_passes_left - VW'(1);
                n_check       = (r_passes_left == VW'(1));
            end
        end
        if (i_ctl.clr_edges) begin
            n_edges_loaded = '0;
            n_eidx         = '0;
        end
        if (ld_dist) begin
            n_vtx = vtx_next;
        end
        if (ld_dist || ld_neg) begin
            n_out_valid = 1'b1;
        end else if (out_free) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edges_loaded <= '0;
            r_eidx         <= '0;
            r_nv           <= NW'(1);
            r_passes_left  <= '0;
            r_check        <= 1'b0;
            r_vtx          <= '0;
            r_known        <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_edges_loaded <= n_edges_loaded;
            r_eidx         <= n_eidx;
            r_nv           <= n_nv;
            r_passes_left  <= n_passes_left;
            r_check        <= n_check;
            r_vtx          <= n_vtx;
            r_known        <= n_known;
            r_out_valid    <= n_out_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (ld_dist) begin
            r_out.vertex_index   <= spre_pkg::VERTEX_W'(r_vtx);
            r_out.path_distance  <= known_v ? dist_rdata_a[spre_pkg::DIST_OUT_W-1:0] : '0;
            r_out.reachable      <= known_v;
            r_out.negative_cycle <= 1'b0;
            r_out.last_result    <= (vtx_next == r_nv);
        end else if (ld_neg) begin
            r_out.vertex_index   <= '0;
            r_out.path_distance  <= '0;
            r_out.reachable      <= 1'b0;
            r_out.negative_cycle <= 1'b1;
            r_out.last_result    <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Status for the sequencer
    assign o_flags.start      = i_in_accept && i_in_data.final_edge;
    assign o_flags.edges_done = (r_eidx == r_edges_loaded);
    assign o_flags.cycle_hit  = r_check && hit;
    assign o_flags.checking   = r_check;
    assign o_flags.out_busy   = !out_free;
    assign o_flags.vtx_done   = (r_vtx == r_nv);

    // Edge pointer never runs past the stored edges
    a_eidx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_eidx <= r_edges_loaded)
        else $error("edge pointer beyond stored edges");

    // Set-up leaves at most the start vertex known
    a_init_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.init |=> $countones(r_known) <= 1)
        else $error("more than one vertex known after set-up");

    // A relaxable edge in the check pass leads straight to the cycle beat
    a_cycle_branch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.relax && r_check && hit) |=> i_ctl.out_neg)
        else $error("negative cycle not reported");

    // Check mode holds until the next run is set up
    a_check_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_check && !i_ctl.init) |=> r_check)
        else $error("check mode dropped mid-run");

    // Last distance beat leaves the vertex counter at the vertex count
    a_last_vtx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ld_dist && (vtx_next == r_nv)) |=> (r_vtx == r_nv))
        else $error("vertex counter out of step with last result");

endmodule

`default_nettype wire

FILE: rtl/shortest_path_relaxation_engine_top.sv
// Top level of the shortest-path relaxation engine: configuration registers and wiring.
//
// Edges arrive on the input channel (valid/stall), one beat per cycle while the engine
// is idle, and are kept in arrival order; beats past the edge store depth are dropped.
// A beat with final_edge set starts a run; the input stalls until the run's results
// have all been loaded into the output register and the sequencer is back at idle.
// A run takes one set-up step, then V passes (V-1 relaxing, one check), where V is the
// clamped vertex count. Each edge visit costs three sequencer steps (edge fetch,
// distance fetch, relax and write back), since both stores read through registered
// ports, and each pass two more steps to close it. The check pass stops early on the
// first relaxable edge. V distance beats then follow, each through an output read,
// a load and an advance step, or a single negative-cycle beat is loaded straight away.
// Results leave through a registered output; while the receiver stalls, the beat is
// held and the sequencer waits. The configuration port is always ready and should be
// written only while idle. Reset empties the edge store, sets vertex count 64 and start
// vertex 0, and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module shortest_path_relaxation_engine_top #(
    parameter int MAX_VERTICES = spre_pkg::MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = spre_pkg::MAX_EDGES_DEF,
    parameter int WEIGHT_BITS  = spre_pkg::WEIGHT_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Edge input
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire spre_pkg::t_in_beat                 i_in_data,
    // Result output
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output spre_pkg::t_out_beat                     o_out_data,
    // Configuration writes
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [spre_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [spre_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    logic [spre_pkg::VCOUNT_W-1:0] r_vertex_count;
    logic [spre_pkg::VERTEX_W-1:0] r_start_vertex;
    spre_pkg::t_ctl                ctl;
    spre_pkg::t_flags              flags;
    logic                          in_accept;

    // Configuration registers, unknown indexes ignored
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= spre_pkg::VERTEX_COUNT_RST;
            r_start_vertex <= spre_pkg::START_VERTEX_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                spre_pkg::CFG_VERTEX_COUNT: begin
                    r_vertex_count <= i_cfg_data[spre_pkg::VCOUNT_W-1:0];
                end
                spre_pkg::CFG_START_VERTEX: begin
                    r_start_vertex <= i_cfg_data[spre_pkg::VERTEX_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Input is open only on the idle step
    assign o_in_stall = !ctl.in_open;
    assign in_accept  = i_in_valid && ctl.in_open;

    spre_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_ctl   (ctl)
    );

    spre_dpath #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .o_flags        (flags),
        .i_vertex_count (r_vertex_count),
        .i_start_vertex (r_start_vertex),
        .i_in_accept    (in_accept),
        .i_in_data      (i_in_data),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_data     (o_out_data)
    );

endmodule

`default_nettype wire

FILE: bench/tb_shortest_path_relaxation_engine_top.sv
// Self-checking testbench for the shortest-path relaxation engine top level.
`timescale 1ns / 1ps

module tb_shortest_path_relaxation_engine_top;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 12;
    localparam int RANDOM_ITEMS  = 150;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 1000000;

    // Register indexes past the end of the register list, written to show they are ignored
    localparam logic [spre_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [spre_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef struct {
        logic [spre_pkg::VERTEX_W-1:0] src;
        logic [spre_pkg::VERTEX_W-1:0] dst;
        int                            weight;
    } t_edge_rec;

    // Scoreboard: mirrors the edge store and registers, predicts each run's beats
    class path_scoreboard;
        t_edge_rec                     stored[$];
        logic [spre_pkg::VCOUNT_W-1:0] vcount;
        logic [spre_pkg::VERTEX_W-1:0] svertex;
        longint                        distance[spre_pkg::MAX_VERTICES_DEF];
        bit                            known[spre_pkg::MAX_VERTICES_DEF];
        spre_pkg::t_out_beat           awaited[$];
        int                            errors;
        int                            runs;
        int                            cycles_found;
        int                            results_seen;
        int                            edges_seen;

        function new();
            vcount       = spre_pkg::VERTEX_COUNT_RST;
            svertex      = spre_pkg::START_VERTEX_RST;
            errors       = 0;
            runs         = 0;
            cycles_found = 0;
            results_seen = 0;
            edges_seen   = 0;
        endfunction

        function void set_reg(logic [spre_pkg::CFG_IDX_W-1:0] idx,
                              logic [spre_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                spre_pkg::CFG_VERTEX_COUNT: vcount = data[spre_pkg::VCOUNT_W-1:0];
                spre_pkg::CFG_START_VERTEX: svertex = data[spre_pkg::VERTEX_W-1:0];
                default: ;
            endcase
        endfunction

        // True if the edge would shorten its destination; applies it when asked
        function bit relax(t_edge_rec e, int nv, bit apply);
            longint cand;
            if (e.src >= nv || e.dst >= nv)
                return 1'b0;
            if (!known[e.src])
                return 1'b0;
            cand = distance[e.src] + longint'(e.weight);
            if (known[e.dst] && distance[e.dst] <= cand)
                return 1'b0;
            if (apply) begin
                distance[e.dst] = cand;
                known[e.dst]    = 1'b1;
            end
            return 1'b1;
        endfunction

        function void note_edge(spre_pkg::t_in_beat b);
            t_edge_rec           e;
            spre_pkg::t_out_beat r;
            int                  nv;
            int                  p;
            int                  v;
            bit                  neg;
            edges_seen++;
            if (stored.size() < spre_pkg::MAX_EDGES_DEF) begin
                e.src    = b.edge_from;
                e.dst    = b.edge_to;
                e.weight = int'($signed(b.edge_weight));
                stored.push_back(e);
            end
            if (!b.final_edge)
                return;

            // clamp the vertex count as the engine does
            nv = int'(vcount);
            if (nv < 1)
                nv = 1;
            if (nv > spre_pkg::MAX_VERTICES_DEF)
                nv = spre_pkg::MAX_VERTICES_DEF;
            foreach (distance[i]) begin
                distance[i] = 0;
                known[i]    = 1'b0;
            end
            if (svertex < nv)
                known[svertex] = 1'b1;

            for (p = 0; p + 1 < nv; p++)
                foreach (stored[i])
                    void'(relax(stored[i], nv, 1'b1));
            neg = 1'b0;
            foreach (stored[i])
                if (!neg)
                    neg = relax(stored[i], nv, 1'b0);
            stored.delete();
            runs++;

            if (neg) begin
                r = '0;
                r.negative_cycle = 1'b1;
                r.last_result    = 1'b1;
                awaited.push_back(r);
                cycles_found++;
            end else begin
                for (v = 0; v < nv; v++) begin
                    r = '0;
                    r.vertex_index = v[spre_pkg::VERTEX_W-1:0];
                    if (known[v]) begin
                        r.path_distance = distance[v][spre_pkg::DIST_OUT_W-1:0];
                        r.reachable     = 1'b1;
                    end
                    r.last_result = (v + 1 == nv);
                    awaited.push_back(r);
                end
            end
        endfunction

        function void check_result(spre_pkg::t_out_beat got);
            spre_pkg::t_out_beat want;
            results_seen++;
            if (awaited.size() == 0) begin
                $error("result beat with nothing awaited: vertex_index %0d", got.vertex_index);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (got.vertex_index !== want.vertex_index) begin
                $error("vertex_index: expected %0d, got %0d", want.vertex_index,
                       got.vertex_index);
                errors++;
            end
            if (got.path_distance !== want.path_distance) begin
                $error("path_distance: expected %0d, got %0d", want.path_distance,
                       got.path_distance);
                errors++;
            end
            if (got.reachable !== want.reachable) begin
                $error("reachable: expected %0d, got %0d", want.reachable, got.reachable);
                errors++;
            end
            if (got.negative_cycle !== want.negative_cycle) begin
                $error("negative_cycle: expected %0d, got %0d", want.negative_cycle,
                       got.negative_cycle);
                errors++;
            end
            if (got.last_result !== want.last_result) begin
                $error("last_result: expected %0d, got %0d", want.last_result,
                       got.last_result);
                errors++;
            end
        endfunction
    endclass

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_stall;
    spre_pkg::t_in_beat              in_data = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    spre_pkg::t_out_beat             out_data;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [spre_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [spre_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    bit calm = 1'b0;
    bit quiet = 1'b0;
    int stall_left = 0;
    int phase_count = 0;
    int cycle_count = 0;

    path_scoreboard sb = new();

    shortest_path_relaxation_engine_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Timeout guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Alternate stretches with and without idling
    always @(negedge i_clk) begin
        phase_count <= phase_count + 1;
        if (phase_count % 48 == 0)
            quiet <= ($urandom_range(0, 3) == 0);
    end

    // Receiver stalls in bursts of random length
    always @(negedge i_clk) begin
        if (!i_rst_n || calm || quiet) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 4) == 0) begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 6);
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Beat monitors, sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_valid && cfg_ready)
                sb.set_reg(cfg_index, cfg_data);
            if (in_valid && !in_stall)
                sb.note_edge(in_data);
            if (out_valid && !out_stall)
                sb.check_result(out_data);
        end
    end

    // One edge beat, with an occasional gap ahead of it
    task automatic send_edge(input int from_v, input int to_v, input int weight, input bit fin);
        spre_pkg::t_in_beat b;
        int                 gap;
        if (!calm && !quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        b.edge_from   = from_v[spre_pkg::VERTEX_W-1:0];
        b.edge_to     = to_v[spre_pkg::VERTEX_W-1:0];
        b.edge_weight = weight[spre_pkg::WEIGHT_W-1:0];
        b.final_edge  = fin;
        in_valid <= 1'b1;
        in_data  <= b;
        do @(posedge i_clk); while (in_stall);
        @(negedge i_clk);
    endtask

    // Hold the sender until every awaited beat has arrived and the engine is idle
    task automatic wait_drain();
        in_valid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [spre_pkg::CFG_IDX_W-1:0] idx,
                             input logic [spre_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
    endtask

    // Registers change only with the engine idle; bit 6 of the start write is don't-care
    task automatic apply_config(input int vc, input int sv, input bit spare);
        wait_drain();
        write_reg(spre_pkg::CFG_VERTEX_COUNT, vc[spre_pkg::CFG_DATA_W-1:0]);
        write_reg(spre_pkg::CFG_START_VERTEX,
                  {1'($urandom_range(0, 1)), sv[spre_pkg::VERTEX_W-1:0]});
        if (spare)
            write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                      spre_pkg::CFG_DATA_W'($urandom_range(0, 127)));
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int touched[$];
        int sent;
        int vc;
        int nv;
        int sv;
        int n_edges;
        int wmode;
        int from_v;
        int to_v;
        int w;
        int k;
        bit first;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset defaults: 64 vertices from vertex 0, field extremes
        send_edge(0, 63, 32767, 1'b0);
        send_edge(63, 1, -32768, 1'b0);
        send_edge(1, 62, -1, 1'b1);

        // Negative cycle reachable from the start
        apply_config(4, 3, 1'b0);
        send_edge(3, 1, -5, 1'b0);
        send_edge(1, 2, 1, 1'b0);
        send_edge(2, 1, -2, 1'b1);

        // Unreachable negative cycle and edges with endpoints out of range
        apply_config(5, 0, 1'b1);
        send_edge(0, 1, 7, 1'b0);
        send_edge(1, 4, -3, 1'b0);
        send_edge(2, 3, -4, 1'b0);
        send_edge(3, 2, 1, 1'b0);
        send_edge(0, 9, 1, 1'b0);
        send_edge(40, 0, -9, 1'b1);

        // Start vertex beyond the vertex count: nothing reachable
        apply_config(3, 5, 1'b0);
        send_edge(0, 1, 2, 1'b0);
        send_edge(5, 0, 1, 1'b1);

        // Vertex count zero acts as one
        apply_config(0, 0, 1'b0);
        send_edge(0, 0, -1, 1'b1);
        wait_drain();
        send_edge(0, 0, 5, 1'b1);

        // Vertex count above the maximum clamps; top start vertex
        apply_config(127, 63, 1'b0);
        send_edge(63, 0, -32768, 1'b0);
        send_edge(0, 1, 32767, 1'b1);

        // A graph of one final edge
        apply_config(2, 1, 1'b0);
        send_edge(1, 0, -100, 1'b1);

        // Random graphs: mostly grown out from the start vertex, some noise edges
        sent  = 0;
        first = 1'b1;
        while (sent < RANDOM_ITEMS) begin
            calm <= (sent >= RANDOM_ITEMS * 4 / 5);
            if (first || $urandom_range(0, 2) != 0) begin
                k = $urandom_range(0, 15);
                if (k == 0)
                    vc = $urandom_range(0, 1) ? 0 : $urandom_range(65, 127);
                else if (k < 3)
                    vc = $urandom_range(11, 64);
                else
                    vc = $urandom_range(1, 10);
                nv = (vc < 1) ? 1 :
                     (vc > spre_pkg::MAX_VERTICES_DEF) ? spre_pkg::MAX_VERTICES_DEF : vc;
                sv = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63)
                                                 : $urandom_range(0, nv - 1);
                apply_config(vc, sv, $urandom_range(0, 3) == 0);
                first = 1'b0;
            end else begin
                wait_drain();
            end
            nv = int'(sb.vcount);
            nv = (nv < 1) ? 1 :
                 (nv > spre_pkg::MAX_VERTICES_DEF) ? spre_pkg::MAX_VERTICES_DEF : nv;
            n_edges = $urandom_range(1, 14);
            wmode   = $urandom_range(0, 3);
            touched.delete();
            touched.push_back(int'(sb.svertex));
            for (k = 0; k < n_edges; k++) begin
                if ($urandom_range(0, 7) == 0) begin
                    from_v = $urandom_range(0, 63);
                    to_v   = $urandom_range(0, 63);
                end else begin
                    from_v = $urandom_range(0, 1) ? touched[$urandom_range(0, touched.size() - 1)]
                                                  : $urandom_range(0, nv - 1);
                    to_v   = $urandom_range(0, nv - 1);
                    touched.push_back(to_v);
                end
                case (wmode)
                    0: w = $urandom_range(0, 1000);
                    1: w = $urandom_range(0, 1060) - 60;
                    2: w = $urandom_range(0, 65535) - 32768;
                    default: w = $urandom_range(0, 2000) - 1000;
                endcase
                send_edge(from_v, to_v, w, k == n_edges - 1);
                sent++;
            end
        end

        wait_drain();

        $display("Covered %0d edges over %0d runs: %0d negative-cycle verdicts, %0d beats checked.",
                 sb.edges_seen, sb.runs, sb.cycles_found, sb.results_seen);
        $display("Vertex counts 0 to 127, start vertices in and out of range, stray endpoints.");
        if (sb.errors == 0 && sb.awaited.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/spre_pkg.sv
rtl/spre_ram.sv
rtl/spre_seq.sv
rtl/spre_dpath.sv
rtl/shortest_path_relaxation_engine_top.sv
bench/tb_shortest_path_relaxation_engine_top.sv
